>>> rtl/core/pdp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pdp_pkg;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } point_t;

  typedef struct packed {
    logic signed [31:0] pixel_u;
    logic signed [31:0] pixel_v;
    logic               point_valid;
    logic               distortion_clipped;
  } pixel_t;

  // Configuration register indexes
  localparam logic [2:0] CFG_K1 = 3'd0;
  localparam logic [2:0] CFG_K2 = 3'd1;
  localparam logic [2:0] CFG_K3 = 3'd2;
  localparam logic [2:0] CFG_P1 = 3'd3;
  localparam logic [2:0] CFG_P2 = 3'd4;
  localparam logic [2:0] CFG_FX = 3'd5;
  localparam logic [2:0] CFG_FY = 3'd6;
  localparam logic [2:0] CFG_PP = 3'd7;

  localparam logic [31:0] FOCAL_RESET = 32'd65536000;

  typedef logic signed [51:0] wide_t;

  localparam logic [46:0] WMAX     = {47{1'b1}};
  localparam wide_t       ONE_Q24  = 52'sd16777216;
  localparam wide_t       RD_LOW   = 52'sd13421773;
  localparam wide_t       RD_HIGH  = 52'sd20132659;
  localparam wide_t       S32_MAX  = 52'sd2147483647;
  localparam wide_t       S32_MIN  = -52'sd2147483648;

  // Pipeline stage map
  localparam int S_DIV_END   = 47;
  localparam int S_SQ        = 48;
  localparam int S_SQ_FIN    = 49;
  localparam int S_R2        = 50;
  localparam int S_RM1       = 51;
  localparam int S_RF1       = 52;
  localparam int S_RA1       = 53;
  localparam int S_RM2       = 54;
  localparam int S_RF2       = 55;
  localparam int S_RA2       = 56;
  localparam int S_RM3       = 57;
  localparam int S_RF3       = 58;
  localparam int S_RD        = 59;
  localparam int S_TM        = 60;
  localparam int S_TF        = 61;
  localparam int S_TS        = 62;
  localparam int S_FM        = 63;
  localparam int S_FF        = 64;
  localparam int S_PIX       = 65;
  localparam int S_SQRT_END  = 89;
  localparam int S_NINIT     = 90;
  localparam int S_NDIV_END  = 115;
  localparam int S_OFF       = 116;
  localparam int S_OUT       = 117;
  localparam int N_STAGES    = 118;

  // Sign and magnitude, magnitude held at or below WMAX
  typedef struct packed {
    logic        neg;
    logic [46:0] mag;
  } sm_t;

  // Partial products of a 47 x 47 bit magnitude product
  typedef struct packed {
    logic        neg;
    logic [47:0] ll;
    logic [46:0] lh;
    logic [46:0] hl;
    logic [45:0] hh;
  } mp_t;

  function automatic wide_t sx32(logic [31:0] v);
    return {{20{v[31]}}, v};
  endfunction

  function automatic sm_t sm_from_wide(wide_t v);
    logic [51:0] m;
    sm_t         r;
    m     = v[51] ? (~v + 52'd1) : v;
    r.neg = v[51];
    r.mag = (m > {5'b0, WMAX}) ? WMAX : m[46:0];
    return r;
  endfunction

  function automatic wide_t wide_from_sm(sm_t s);
    wide_t w;
    w = {5'b0, s.mag};
    return s.neg ? -w : w;
  endfunction

  function automatic mp_t mul_part(sm_t a, sm_t b);
    mp_t r;
    r.neg = a.neg ^ b.neg;
    r.ll  = a.mag[23:0] * b.mag[23:0];
    r.lh  = a.mag[23:0] * b.mag[46:24];
    r.hl  = a.mag[46:24] * b.mag[23:0];
    r.hh  = a.mag[46:24] * b.mag[46:24];
    return r;
  endfunction

  // Product shifted down by 24; saturate when it spills past 64 bits
  function automatic sm_t mul_fin(mp_t p);
    logic [93:0] f;
    sm_t         r;
    f = {46'b0, p.ll} + ({47'b0, p.lh} << 24) + ({47'b0, p.hl} << 24) + {p.hh, 48'b0};
    r.neg = p.neg;
    r.mag = (|f[93:64]) ? WMAX : {7'b0, f[63:24]};
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(wide_t v);
    if (v > S32_MAX) begin
      return 32'sh7fffffff;
    end else if (v < S32_MIN) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic [63:0] isqrt_const(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] rem;
    logic [63:0] bt;
    r   = '0;
    rem = v;
    for (int i = 31; i >= 0; i--) begin
      bt = 64'd1 << (2 * i);
      if (rem >= r + bt) begin
        rem = rem - (r + bt);
        r   = (r >> 1) + bt;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/pinhole_distortion_projection_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// A start transfer is accepted while busy is low; one point per cycle sustained, no stage stalls.
// Most of the pipeline is the 47-step quotient pipeline for x/z and y/z, the 24-step root
// pipeline and the 25-step direction divider, each one bit per stage.
// Synchronous active-low reset empties the pipeline, loads register defaults, holds busy high.
// Results are strobed for one cycle; the receiver cannot stall.

module pinhole_distortion_projection_unit #(
  parameter int IMAGE_WIDTH  = 1920,
  parameter int IMAGE_HEIGHT = 1080
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  pdp_pkg::point_t   in_point,
  output logic              out_strobe,
  output pdp_pkg::pixel_t   out_pixel,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [47:0]       cfg_data
);

  localparam int NS = pdp_pkg::N_STAGES;
  localparam logic [63:0] DIAG_SQ =
    64'(IMAGE_WIDTH * IMAGE_WIDTH + IMAGE_HEIGHT * IMAGE_HEIGHT);
  localparam logic [28:0] RADIUS = 29'(pdp_pkg::isqrt_const(DIAG_SQ << 32));
  localparam logic signed [31:0] U_MAX = 32'(IMAGE_WIDTH * 65536);
  localparam logic signed [31:0] V_MAX = 32'(IMAGE_HEIGHT * 65536);

  typedef struct packed {
    logic                   behind;
    logic                   neg_u;
    logic                   neg_v;
    logic                   ovf_u;
    logic                   ovf_v;
    logic [30:0]            den;
    logic [55:0]            rem_u;
    logic [55:0]            rem_v;
    logic [46:0]            q_u;
    logic [46:0]            q_v;
    logic [46:0]            mag_u;
    logic [46:0]            mag_v;
    pdp_pkg::mp_t [5:0]     mp;
    pdp_pkg::sm_t [5:0]     pr;
    pdp_pkg::sm_t           uu;
    pdp_pkg::sm_t           vv;
    pdp_pkg::sm_t           uv;
    pdp_pkg::sm_t           r2;
    pdp_pkg::sm_t           tu;
    pdp_pkg::sm_t           tv;
    pdp_pkg::sm_t           acc;
    pdp_pkg::sm_t           rd;
    pdp_pkg::sm_t           und;
    pdp_pkg::sm_t           vnd;
    logic                   clipped;
    logic signed [31:0]     pu;
    logic signed [31:0]     pv;
    logic [47:0]            sq_v;
    logic [47:0]            sq_r;
    logic [23:0]            norm;
    logic                   norm_zero;
    logic                   dovf_u;
    logic                   dovf_v;
    logic [58:0]            drem_u;
    logic [58:0]            drem_v;
    logic [24:0]            dq_u;
    logic [24:0]            dq_v;
    logic [53:0]            op_u;
    logic [53:0]            op_v;
    pdp_pkg::pixel_t        res;
  } st_t;

  logic [31:0] k1_r, k2_r, k3_r, p1_r, p2_r, fx_r, fy_r;
  logic [47:0] pp_r;
  logic        busy_r;
  logic        accept;
  logic [NS-1:0] valid_r;
  st_t         pipe_r [0:NS-1];

  assign busy      = busy_r;
  assign cfg_ready = ~busy_r;
  assign accept    = start && !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k1_r <= '0;
      k2_r <= '0;
      k3_r <= '0;
      p1_r <= '0;
      p2_r <= '0;
      fx_r <= pdp_pkg::FOCAL_RESET;
      fy_r <= pdp_pkg::FOCAL_RESET;
      pp_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pdp_pkg::CFG_K1: k1_r <= cfg_data[31:0];
        pdp_pkg::CFG_K2: k2_r <= cfg_data[31:0];
        pdp_pkg::CFG_K3: k3_r <= cfg_data[31:0];
        pdp_pkg::CFG_P1: p1_r <= cfg_data[31:0];
        pdp_pkg::CFG_P2: p2_r <= cfg_data[31:0];
        pdp_pkg::CFG_FX: fx_r <= cfg_data[31:0];
        pdp_pkg::CFG_FY: fy_r <= cfg_data[31:0];
        pdp_pkg::CFG_PP: pp_r <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic st_t stage_init(pdp_pkg::point_t p);
    st_t         n;
    logic [31:0] xu;
    logic [31:0] yu;
    logic [31:0] mx;
    logic [31:0] my;
    n  = '0;
    xu = p.point_x;
    yu = p.point_y;
    mx = xu[31] ? (~xu + 32'd1) : xu;
    my = yu[31] ? (~yu + 32'd1) : yu;
    n.behind = p.point_z[31] || (p.point_z == 32'sd0);
    n.neg_u  = xu[31];
    n.neg_v  = yu[31];
    n.den    = p.point_z[30:0];
    n.rem_u  = {mx, 24'b0};
    n.rem_v  = {my, 24'b0};
    // quotient of 2^47 or more saturates
    n.ovf_u  = {22'b0, mx} >= {n.den, 23'b0};
    n.ovf_v  = {22'b0, my} >= {n.den, 23'b0};
    return n;
  endfunction

  function automatic st_t stage_fn(st_t s, int k);
    st_t                n;
    int                 i;
    logic [77:0]        dd;
    logic [58:0]        d2;
    logic [48:0]        t;
    logic [47:0]        bt;
    logic [24:0]        cu;
    logic [24:0]        cv;
    pdp_pkg::wide_t     wu;
    pdp_pkg::wide_t     wv;
    pdp_pkg::wide_t     cxw;
    pdp_pkg::wide_t     cyw;
    pdp_pkg::sm_t       su;
    pdp_pkg::sm_t       sv;
    logic signed [31:0] fu;
    logic signed [31:0] fv;
    n   = s;
    cxw = {24'b0, pp_r[23:0], 4'b0};
    cyw = {24'b0, pp_r[47:24], 4'b0};
    if (k <= pdp_pkg::S_DIV_END) begin
      i  = pdp_pkg::S_DIV_END - k;
      dd = 78'(s.den) << i;
      if ({22'b0, s.rem_u} >= dd) begin
        n.rem_u  = s.rem_u - dd[55:0];
        n.q_u[i] = 1'b1;
      end
      if ({22'b0, s.rem_v} >= dd) begin
        n.rem_v  = s.rem_v - dd[55:0];
        n.q_v[i] = 1'b1;
      end
    end else if (k == pdp_pkg::S_SQ) begin
      n.mag_u = s.q_u | {47{s.ovf_u}};
      n.mag_v = s.q_v | {47{s.ovf_v}};
      su.neg = s.neg_u;
      su.mag = n.mag_u;
      sv.neg = s.neg_v;
      sv.mag = n.mag_v;
      n.mp[0] = pdp_pkg::mul_part(su, su);
      n.mp[1] = pdp_pkg::mul_part(sv, sv);
      n.mp[2] = pdp_pkg::mul_part(su, sv);
    end else if (k == pdp_pkg::S_SQ_FIN) begin
      for (int j = 0; j < 3; j++) begin
        n.pr[j] = pdp_pkg::mul_fin(s.mp[j]);
      end
    end else if (k == pdp_pkg::S_R2) begin
      n.uu = s.pr[0];
      n.vv = s.pr[1];
      n.uv = s.pr[2];
      n.r2 = pdp_pkg::sm_from_wide(pdp_pkg::wide_from_sm(s.pr[0])
                                   + pdp_pkg::wide_from_sm(s.pr[1]));
    end else if (k == pdp_pkg::S_RM1) begin
      n.mp[0] = pdp_pkg::mul_part(s.r2, pdp_pkg::sm_from_wide(pdp_pkg::sx32(k3_r)));
      n.tu = pdp_pkg::sm_from_wide(pdp_pkg::wide_from_sm(s.r2)
                                   + (pdp_pkg::wide_from_sm(s.uu) <<< 1));
      n.tv = pdp_pkg::sm_from_wide(pdp_pkg::wide_from_sm(s.r2)
                                   + (pdp_pkg::wide_from_sm(s.vv) <<< 1));
    end else if (k == pdp_pkg::S_RF1 || k == pdp_pkg::S_RF2 || k == pdp_pkg::S_RF3) begin
      n.pr[0] = pdp_pkg::mul_fin(s.mp[0]);
    end else if (k == pdp_pkg::S_RA1) begin
      n.acc = pdp_pkg::sm_from_wide(pdp_pkg::sx32(k2_r) + pdp_pkg::wide_from_sm(s.pr[0]));
    end else if (k == pdp_pkg::S_RM2 || k == pdp_pkg::S_RM3) begin
      n.mp[0] = pdp_pkg::mul_part(s.r2, s.acc);
    end else if (k == pdp_pkg::S_RA2) begin
      n.acc = pdp_pkg::sm_from_wide(pdp_pkg::sx32(k1_r) + pdp_pkg::wide_from_sm(s.pr[0]));
    end else if (k == pdp_pkg::S_RD) begin
      n.rd = pdp_pkg::sm_from_wide(pdp_pkg::ONE_Q24 + pdp_pkg::wide_from_sm(s.pr[0]));
    end else if (k == pdp_pkg::S_TM) begin
      wu = pdp_pkg::wide_from_sm(s.rd);
      n.clipped = (wu <= pdp_pkg::RD_LOW) || (wu >= pdp_pkg::RD_HIGH);
      su.neg = s.neg_u;
      su.mag = s.mag_u;
      sv.neg = s.neg_v;
      sv.mag = s.mag_v;
      n.mp[0] = pdp_pkg::mul_part(su, s.rd);
      n.mp[1] = pdp_pkg::mul_part(pdp_pkg::sm_from_wide(pdp_pkg::sx32(p1_r) <<< 1), s.uv);
      n.mp[2] = pdp_pkg::mul_part(pdp_pkg::sm_from_wide(pdp_pkg::sx32(p2_r)), s.tu);
      n.mp[3] = pdp_pkg::mul_part(sv, s.rd);
      n.mp[4] = pdp_pkg::mul_part(pdp_pkg::sm_from_wide(pdp_pkg::sx32(p1_r)), s.tv);
      n.mp[5] = pdp_pkg::mul_part(pdp_pkg::sm_from_wide(pdp_pkg::sx32(p2_r) <<< 1), s.uv);
    end else if (k == pdp_pkg::S_TF) begin
      for (int j = 0; j < 6; j++) begin
        n.pr[j] = pdp_pkg::mul_fin(s.mp[j]);
      end
    end else if (k == pdp_pkg::S_TS) begin
      n.und = pdp_pkg::sm_from_wide(pdp_pkg::wide_from_sm(s.pr[0])
                                    + pdp_pkg::wide_from_sm(s.pr[1])
                                    + pdp_pkg::wide_from_sm(s.pr[2]));
      n.vnd = pdp_pkg::sm_from_wide(pdp_pkg::wide_from_sm(s.pr[3])
                                    + pdp_pkg::wide_from_sm(s.pr[4])
                                    + pdp_pkg::wide_from_sm(s.pr[5]));
    end else if (k == pdp_pkg::S_FM) begin
      su.neg = 1'b0;
      su.mag = {15'b0, fx_r};
      sv.neg = 1'b0;
      sv.mag = {15'b0, fy_r};
      n.mp[0] = pdp_pkg::mul_part(s.und, su);
      n.mp[1] = pdp_pkg::mul_part(s.vnd, sv);
    end else if (k == pdp_pkg::S_FF) begin
      n.pr[0] = pdp_pkg::mul_fin(s.mp[0]);
      n.pr[1] = pdp_pkg::mul_fin(s.mp[1]);
    end else if (k == pdp_pkg::S_PIX) begin
      n.pu   = pdp_pkg::sat32(pdp_pkg::wide_from_sm(s.pr[0]) + cxw);
      n.pv   = pdp_pkg::sat32(pdp_pkg::wide_from_sm(s.pr[1]) + cyw);
      n.sq_v = {1'b0, s.r2.mag};
      n.sq_r = '0;
    end else if (k <= pdp_pkg::S_SQRT_END) begin
      // one root bit per stage
      bt = 48'd1 << (2 * (pdp_pkg::S_SQRT_END - k));
      t  = {1'b0, s.sq_r} + {1'b0, bt};
      if ({1'b0, s.sq_v} >= t) begin
        n.sq_v = s.sq_v - t[47:0];
        n.sq_r = (s.sq_r >> 1) + bt;
      end else begin
        n.sq_r = s.sq_r >> 1;
      end
    end else if (k == pdp_pkg::S_NINIT) begin
      n.norm      = s.sq_r[23:0];
      n.norm_zero = (s.sq_r[23:0] == 24'd0);
      n.dovf_u    = s.mag_u >= {10'b0, s.sq_r[23:0], 13'b0};
      n.dovf_v    = s.mag_v >= {10'b0, s.sq_r[23:0], 13'b0};
      n.drem_u    = {s.mag_u, 12'b0};
      n.drem_v    = {s.mag_v, 12'b0};
      n.dq_u      = '0;
      n.dq_v      = '0;
    end else if (k <= pdp_pkg::S_NDIV_END) begin
      i  = pdp_pkg::S_NDIV_END - k;
      d2 = 59'(s.norm) << i;
      if (s.drem_u >= d2) begin
        n.drem_u  = s.drem_u - d2;
        n.dq_u[i] = 1'b1;
      end
      if (s.drem_v >= d2) begin
        n.drem_v  = s.drem_v - d2;
        n.dq_v[i] = 1'b1;
      end
    end else if (k == pdp_pkg::S_OFF) begin
      // cap the direction cosine at 1.0, zero when the norm is zero
      cu = (s.dovf_u || s.dq_u[24]) ? 25'h1000000 : s.dq_u;
      cv = (s.dovf_v || s.dq_v[24]) ? 25'h1000000 : s.dq_v;
      if (s.norm_zero) begin
        cu = '0;
        cv = '0;
      end
      n.op_u = cu * RADIUS;
      n.op_v = cv * RADIUS;
    end else begin
      wu = {22'b0, s.op_u[53:24]};
      wv = {22'b0, s.op_v[53:24]};
      wu = s.neg_u ? -wu : wu;
      wv = s.neg_v ? -wv : wv;
      fu = s.clipped ? pdp_pkg::sat32(wu + cxw) : s.pu;
      fv = s.clipped ? pdp_pkg::sat32(wv + cyw) : s.pv;
      if (s.behind) begin
        n.res = '0;
      end else begin
        n.res.pixel_u            = fu;
        n.res.pixel_v            = fv;
        n.res.distortion_clipped = s.clipped;
        n.res.point_valid        = !s.clipped && (fu >= 0) && (fu <= U_MAX)
                                   && (fv >= 0) && (fv <= V_MAX);
      end
    end
    return n;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= {valid_r[NS-2:0], accept};
    end
  end

  // advance every stage each cycle
  always_ff @(posedge clk) begin
    pipe_r[0] <= stage_init(in_point);
    for (int k = 1; k < NS; k++) begin
      pipe_r[k] <= stage_fn(pipe_r[k-1], k);
    end
  end

  assign out_strobe = valid_r[NS-1];
  assign out_pixel  = pipe_r[NS-1].res;

`ifndef SYNTH
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##(NS) out_strobe)
    else $error("transfer did not reach the output on time");

  a_clip_invalid : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !(out_pixel.point_valid && out_pixel.distortion_clipped))
    else $error("clipped pixel marked valid");

  a_valid_inside : assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_pixel.point_valid) |->
      (!out_pixel.pixel_u[31] && !out_pixel.pixel_v[31]))
    else $error("valid pixel outside the image");
`endif

endmodule

`default_nettype wire
